FILE: rtl/drmt_pkg.sv
// shared constants, port layout and command type for the dual range max tree
// no dependencies; used by every module of the block
`default_nettype none

package drmt_pkg;

   // tree geometry
   localparam int MAX_ENTRIES = 1024;
   localparam int DEPTH       = 2 * MAX_ENTRIES;
   localparam int NODE_W      = $clog2(DEPTH);
   localparam int PTR_W       = NODE_W + 1;

   // field widths
   localparam int IDX_W  = 11;
   localparam int VAL_W  = 64;
   localparam int WORD_W = 2 * VAL_W;
   localparam int CALC_W = ((IDX_W > PTR_W) ? IDX_W : PTR_W) + 1;

   // request beat layout, lowest bit first
   localparam int REQ_IDX_LSB   = 0;
   localparam int REQ_A_LSB     = REQ_IDX_LSB + IDX_W;
   localparam int REQ_B_LSB     = REQ_A_LSB + VAL_W;
   localparam int REQ_LO_LSB    = REQ_B_LSB + VAL_W;
   localparam int REQ_HI_LSB    = REQ_LO_LSB + IDX_W;
   localparam int REQ_FIELDS_W  = REQ_HI_LSB + IDX_W;
   localparam int REQ_DATA_W    = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W    = WORD_W;

   // command queue between front and engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // one classified item; for a write, left holds the leaf node
   typedef struct packed {
      op_type              op;
      logic                empty;
      logic [PTR_W-1:0]    left;
      logic [PTR_W-1:0]    right;
      logic [WORD_W-1:0]   word;   // {value_b, value_a}
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/drmt_front.sv
// front end: entry count register, request decode, range clipping to tree nodes
// depends on drmt_pkg
`default_nettype none

module drmt_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [drmt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire                              req_tuser,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [drmt_pkg::IDX_W-1:0]       csr_wdata,
   input  wire                              queue_full,
   input  wire                              init_done,
   output logic                             push,
   output drmt_pkg::cmd_type                push_cmd
);

   logic [drmt_pkg::IDX_W-1:0]  count_ff, count_in;
   logic [drmt_pkg::CALC_W-1:0] count_clip, lo, hi, idx, max_n;
   logic [drmt_pkg::IDX_W-1:0]  f_idx, f_lo, f_hi;
   logic [drmt_pkg::VAL_W-1:0]  f_a, f_b;
   drmt_pkg::op_type            op;
   logic                        idx_ok, empty;

   // entry count register, always writable
   assign csr_ready = 1'b1;
   assign count_in  = (csr_valid && csr_ready) ? csr_wdata : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= drmt_pkg::IDX_W'(drmt_pkg::MAX_ENTRIES);
      end else begin
         count_ff <= count_in;
      end
   end

   // unpack the request beat
   assign op    = drmt_pkg::op_type'(req_tuser);
   assign f_idx = req_tdata[drmt_pkg::REQ_IDX_LSB +: drmt_pkg::IDX_W];
   assign f_a   = req_tdata[drmt_pkg::REQ_A_LSB   +: drmt_pkg::VAL_W];
   assign f_b   = req_tdata[drmt_pkg::REQ_B_LSB   +: drmt_pkg::VAL_W];
   assign f_lo  = req_tdata[drmt_pkg::REQ_LO_LSB  +: drmt_pkg::IDX_W];
   assign f_hi  = req_tdata[drmt_pkg::REQ_HI_LSB  +: drmt_pkg::IDX_W];

   // clip the range and map it to half-open leaf node bounds
   always_comb begin
      max_n      = drmt_pkg::CALC_W'(drmt_pkg::MAX_ENTRIES);
      count_clip = drmt_pkg::CALC_W'(count_ff);
      if (count_clip > max_n) begin
         count_clip = max_n;
      end
      lo = drmt_pkg::CALC_W'(f_lo);
      if (lo == '0) begin
         lo = drmt_pkg::CALC_W'(1);
      end
      hi = drmt_pkg::CALC_W'(f_hi);
      if (hi > count_clip) begin
         hi = count_clip;
      end
      empty  = (lo > hi);
      idx    = drmt_pkg::CALC_W'(f_idx);
      idx_ok = (idx != '0) && (idx <= max_n);

      push_cmd       = '0;
      push_cmd.op    = op;
      push_cmd.word  = {f_b, f_a};
      if (op == drmt_pkg::OP_WRITE) begin
         push_cmd.left = drmt_pkg::PTR_W'(max_n + idx - drmt_pkg::CALC_W'(1));
      end else if (empty) begin
         push_cmd.empty = 1'b1;
      end else begin
         push_cmd.left  = drmt_pkg::PTR_W'(max_n + lo - drmt_pkg::CALC_W'(1));
         push_cmd.right = drmt_pkg::PTR_W'(max_n + hi);
      end
   end

   // writes to nonexistent entries are accepted and dropped
   assign req_tready = init_done && !queue_full;
   assign push       = req_tvalid && req_tready && ((op == drmt_pkg::OP_QUERY) || idx_ok);

endmodule

`default_nettype wire

FILE: rtl/drmt_queue.sv
// short command queue that decouples the front end from the tree engine
// depends on drmt_pkg
`default_nettype none

module drmt_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  drmt_pkg::cmd_type  push_cmd,
   input  wire                pop,
   output drmt_pkg::cmd_type  head_cmd,
   output logic               full,
   output logic               empty
);

   drmt_pkg::cmd_type            entries_ff [drmt_pkg::QUEUE_DEPTH];
   logic [drmt_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [drmt_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                         do_push, do_pop;

   assign full     = (count_ff == drmt_pkg::QCNT_W'(drmt_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entries_ff[rd_ptr_ff];

   // pointer and fill count update with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == drmt_pkg::QPTR_W'(drmt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == drmt_pkg::QPTR_W'(drmt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/drmt_engine.sv
// tree engine: node memory with clearing pass, write climb, query walk, result register
// depends on drmt_pkg
`default_nettype none

module drmt_engine (
   input  wire                              clock,
   input  wire                              reset,
   input  drmt_pkg::cmd_type                head_cmd,
   input  wire                              queue_empty,
   output logic                             pop,
   output logic                             init_done,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [drmt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEAF,
      ST_CLIMB,
      ST_QUERY,
      ST_DONE
   } state_type;

   localparam int NW = drmt_pkg::NODE_W;
   localparam int PW = drmt_pkg::PTR_W;
   localparam int WW = drmt_pkg::WORD_W;
   localparam int VW = drmt_pkg::VAL_W;

   state_type         state_ff, state_in;
   logic [NW-1:0]     clr_addr_ff, clr_addr_in;
   logic [NW-1:0]     node_ff, node_in;
   logic [PW-1:0]     left_ff, left_in, right_ff, right_in;
   logic [WW-1:0]     cur_ff, cur_in, acc_ff, acc_in;
   logic              pend_a_ff, pend_a_in, pend_b_ff, pend_b_in;
   logic              empty_ff, empty_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_empty_ff, rsp_empty_in;
   logic [WW-1:0]     rsp_word_ff, rsp_word_in;

   // node memory, word = {b, a}
   logic [WW-1:0]     tree_ff [drmt_pkg::DEPTH];
   logic [WW-1:0]     rd_a_ff, rd_b_ff;
   logic              mem_we;
   logic [NW-1:0]     mem_waddr, rd_addr_a, rd_addr_b, parent;
   logic [WW-1:0]     mem_wdata, cand, climb_word;
   logic [PW-1:0]     right_m1;

   // lane-wise maximum of two value pairs
   function automatic logic [WW-1:0] pair_max(input logic [WW-1:0] x, input logic [WW-1:0] y);
      logic [VW-1:0] lo_v, hi_v;
      lo_v = (x[VW-1:0] > y[VW-1:0]) ? x[VW-1:0] : y[VW-1:0];
      hi_v = (x[WW-1:VW] > y[WW-1:VW]) ? x[WW-1:VW] : y[WW-1:VW];
      return {hi_v, lo_v};
   endfunction

   assign parent     = node_ff >> 1;
   assign climb_word = pair_max(cur_ff, rd_a_ff);
   assign right_m1   = right_ff - 1'b1;
   assign cand       = pair_max(pend_a_ff ? rd_a_ff : '0, pend_b_ff ? rd_b_ff : '0);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      node_in      = node_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      cur_in       = cur_ff;
      empty_in     = empty_ff;
      pend_a_in    = 1'b0;
      pend_b_in    = 1'b0;
      acc_in       = pair_max(acc_ff, cand);
      rsp_word_in  = rsp_word_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      rd_addr_a    = '0;
      rd_addr_b    = '0;
      pop          = 1'b0;

      case (state_ff)
         // zero every node after reset
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == NW'(drmt_pkg::DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // take the next command from the queue
         ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               left_in  = head_cmd.left;
               right_in = head_cmd.right;
               cur_in   = head_cmd.word;
               empty_in = head_cmd.empty;
               acc_in   = '0;
               state_in = (head_cmd.op == drmt_pkg::OP_WRITE) ? ST_LEAF : ST_QUERY;
            end
         end
         // store the leaf and fetch its sibling
         ST_LEAF: begin
            mem_we    = 1'b1;
            mem_waddr = left_ff[NW-1:0];
            mem_wdata = cur_ff;
            rd_addr_a = left_ff[NW-1:0] ^ NW'(1);
            node_in   = left_ff[NW-1:0];
            state_in  = ST_CLIMB;
         end
         // one level per cycle: parent = max(child, sibling)
         ST_CLIMB: begin
            mem_we    = 1'b1;
            mem_waddr = parent;
            mem_wdata = climb_word;
            cur_in    = climb_word;
            node_in   = parent;
            rd_addr_a = parent ^ NW'(1);
            if (parent == NW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         // bottom-up range walk, both bounds per cycle
         ST_QUERY: begin
            if (left_ff < right_ff) begin
               rd_addr_a = left_ff[NW-1:0];
               rd_addr_b = right_m1[NW-1:0];
               pend_a_in = left_ff[0];
               pend_b_in = right_ff[0];
               left_in   = (left_ff + PW'(left_ff[0])) >> 1;
               right_in  = right_ff >> 1;
            end else begin
               state_in = ST_DONE;
            end
         end
         // hand the result to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = acc_ff;
               rsp_empty_in = empty_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_a_ff    <= 1'b0;
         pend_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_a_ff    <= pend_a_in;
         pend_b_ff    <= pend_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff      <= node_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      cur_ff       <= cur_in;
      acc_ff       <= acc_in;
      empty_ff     <= empty_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= tree_ff[rd_addr_a];
      rd_b_ff <= tree_ff[rd_addr_b];
   end

   assign init_done  = (state_ff != ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_empty_ff;

endmodule

`default_nettype wire

FILE: rtl/dual_range_max_tree.sv
// Dual range maximum tree: two arrays of 64-bit values held as max segment trees in one
// node memory. A write beat stores a value pair at one entry and refreshes its ancestors;
// a query beat returns the maxima of both arrays over low..high, clipped to 1..entry_count
// capped at 1024, with zeros and range_empty set when the clipped range is empty. After
// reset the node memory is cleared one node per cycle while req_tready stays low. A write
// occupies the tree engine for a dequeue, the leaf store and one climb step per tree level;
// a query for a dequeue, one step per level the bounds walk up, a drain and a hand-off.
// The node memory has one write and two read ports. A two-entry command queue and the
// result register let the request side and the result side stall on their own.
// depends on drmt_pkg, drmt_front, drmt_queue, drmt_engine
`default_nettype none

module dual_range_max_tree (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // entry_index, value_a, value_b, range_low, range_high, zero fill
   input  wire  [drmt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op
   input  wire                              req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // max_a, max_b
   output logic [drmt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // range_empty
   output logic                             rsp_tuser,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   // entry_count
   input  wire  [drmt_pkg::IDX_W-1:0]       csr_wdata
);

   drmt_pkg::cmd_type  push_cmd, head_cmd;
   logic               push, pop, queue_full, queue_empty, init_done;

   // request decode and range clipping
   drmt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .init_done  (init_done),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // command queue
   drmt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // tree engine and result register
   drmt_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .pop         (pop),
      .init_done   (init_done),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: rtl/drmt_checker.sv
// port-level checks for the dual range max tree, bound to the top level
// depends on drmt_pkg and dual_range_max_tree
`default_nettype none

module drmt_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tready,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire  [drmt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire                              rsp_tuser
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // an empty range reports zero maxima
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("empty range with nonzero maxima");

   // memory clearing blocks requests right after reset
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // no result can appear straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind dual_range_max_tree drmt_checker u_checker (.*);

`default_nettype wire

FILE: tb/dual_range_max_tree_test.sv
// self-checking testbench for dual_range_max_tree: drives write and query beats,
// predicts both range maxima in a local model of the trees and scoreboards results
// depends on drmt_pkg and the dual_range_max_tree rtl
`timescale 1ns / 100ps

module dual_range_max_tree_test;

   // package constants used here
   localparam int MAX_ENTRIES = drmt_pkg::MAX_ENTRIES;
   localparam int DEPTH       = drmt_pkg::DEPTH;
   localparam int IDX_W       = drmt_pkg::IDX_W;
   localparam int VAL_W       = drmt_pkg::VAL_W;
   localparam int REQ_DATA_W  = drmt_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W  = drmt_pkg::RSP_DATA_W;
   localparam int REQ_IDX_LSB = drmt_pkg::REQ_IDX_LSB;
   localparam int REQ_A_LSB   = drmt_pkg::REQ_A_LSB;
   localparam int REQ_B_LSB   = drmt_pkg::REQ_B_LSB;
   localparam int REQ_LO_LSB  = drmt_pkg::REQ_LO_LSB;
   localparam int REQ_HI_LSB  = drmt_pkg::REQ_HI_LSB;
   localparam drmt_pkg::op_type OP_WRITE = drmt_pkg::OP_WRITE;
   localparam drmt_pkg::op_type OP_QUERY = drmt_pkg::OP_QUERY;

   localparam int SETTLE_CYCLES    = 64;    // worst queued writes plus engine drain
   localparam int RANDOM_PER_PHASE = 200;
   localparam int PHASES           = 7;
   localparam int STEADY_PHASE     = 4;
   localparam int RUN_LIMIT_NS     = 600000;
   localparam int LAST_INDEX       = (1 << IDX_W) - 1;

   localparam logic [VAL_W-1:0] ZERO64 = 64'd0;
   localparam logic [VAL_W-1:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [VAL_W-1:0] max_a;
      logic [VAL_W-1:0] max_b;
      logic             empty;
   } maxima_type;

   typedef struct packed {
      drmt_pkg::op_type op;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
      logic             typed;
      logic [VAL_W-1:0] want_a;
      logic [VAL_W-1:0] want_b;
      logic             want_empty;
   } plan_row_type;

   // directed rows; the typed ones carry their result, the rest go to the predictor
   localparam plan_row_type DIRECTED_PLAN [24] = '{
      // cleared store after reset, empty ranges
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd1, 11'd1024, 1'b1, ZERO64, ZERO64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd0, 11'd0, 1'b1, ZERO64, ZERO64, 1'b1},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd7, 11'd3, 1'b1, ZERO64, ZERO64, 1'b1},
      // extreme values at both ends of the array
      '{OP_WRITE, 11'd1, ONES64, ZERO64, 11'd0, 11'd0, 1'b0, ZERO64, ZERO64, 1'b0},
      '{OP_WRITE, 11'd1024, ZERO64, ONES64, 11'd0, 11'd0, 1'b0, ZERO64, ZERO64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd1, 11'd1024, 1'b1, ONES64, ONES64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd1, 11'd1, 1'b1, ONES64, ZERO64, 1'b0},
      // low bound zero, high bound past the entries in use
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd0, 11'd1, 1'b1, ONES64, ZERO64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd1024, 11'd2047, 1'b1, ZERO64, ONES64, 1'b0},
      // writes outside 1..MAX_ENTRIES are dropped
      '{OP_WRITE, 11'd0, 64'd5, 64'd5, 11'd0, 11'd0, 1'b0, ZERO64, ZERO64, 1'b0},
      '{OP_WRITE, 11'd2047, 64'd6, 64'd6, 11'd0, 11'd0, 1'b0, ZERO64, ZERO64, 1'b0},
      '{OP_WRITE, 11'd1025, 64'd7, 64'd7, 11'd0, 11'd0, 1'b0, ZERO64, ZERO64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd2, 11'd1023, 1'b1, ZERO64, ZERO64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd1, 11'd1, 1'b1, ONES64, ZERO64, 1'b0},
      // alternating bit patterns in the middle
      '{OP_WRITE, 11'd512, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        11'd0, 11'd0, 1'b0, ZERO64, ZERO64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd2, 11'd1023, 1'b1,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd2047, 11'd2047, 1'b1, ZERO64, ZERO64, 1'b1},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd513, 11'd1023, 1'b1, ZERO64, ZERO64, 1'b0},
      // partial ranges across subtree borders
      '{OP_WRITE, 11'd300, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
        11'd0, 11'd0, 1'b0, ZERO64, ZERO64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd200, 11'd400, 1'b0, ZERO64, ZERO64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd256, 11'd1024, 1'b0, ZERO64, ZERO64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd1, 11'd511, 1'b0, ZERO64, ZERO64, 1'b0},
      '{OP_WRITE, 11'd513, 64'h8000_0000_0000_0000, 64'd1, 11'd0, 11'd0, 1'b0,
        ZERO64, ZERO64, 1'b0},
      '{OP_QUERY, 11'd0, ZERO64, ZERO64, 11'd512, 11'd513, 1'b0, ZERO64, ZERO64, 1'b0}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [IDX_W-1:0]      csr_wdata  = '0;

   // local copy of both trees and the entry count
   logic [VAL_W-1:0] node_max_a [0:DEPTH-1];
   logic [VAL_W-1:0] node_max_b [0:DEPTH-1];
   int unsigned      active_count;

   maxima_type awaited_maxima [$];
   bit         steady;
   int         mismatches;
   int         writes_sent;
   int         queries_sent;
   int         results_seen;
   int         empties_seen;

   dual_range_max_tree u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // store a pair at a leaf and refresh every ancestor
   function automatic void store_entry_pair(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] a,
                                            logic [VAL_W-1:0] b);
      int unsigned node;
      if (idx < 1 || idx > MAX_ENTRIES) return;
      node = MAX_ENTRIES + idx - 1;
      node_max_a[node] = a;
      node_max_b[node] = b;
      while (node > 1) begin
         node = node >> 1;
         node_max_a[node] = (node_max_a[2*node] > node_max_a[2*node+1]) ?
                            node_max_a[2*node] : node_max_a[2*node+1];
         node_max_b[node] = (node_max_b[2*node] > node_max_b[2*node+1]) ?
                            node_max_b[2*node] : node_max_b[2*node+1];
      end
   endfunction

   // bottom-up walk over the clipped range
   function automatic maxima_type predict_maxima(logic [IDX_W-1:0] lo_raw,
                                                 logic [IDX_W-1:0] hi_raw);
      int unsigned limit, lo, hi, left, right;
      maxima_type r;
      r = '0;
      limit = (active_count > MAX_ENTRIES) ? MAX_ENTRIES : active_count;
      lo = (lo_raw < 1) ? 1 : lo_raw;
      hi = (hi_raw > limit) ? limit : hi_raw;
      if (lo > hi) begin
         r.empty = 1'b1;
         return r;
      end
      left  = MAX_ENTRIES + lo - 1;
      right = MAX_ENTRIES + hi;
      while (left < right) begin
         if (left[0]) begin
            if (node_max_a[left] > r.max_a) r.max_a = node_max_a[left];
            if (node_max_b[left] > r.max_b) r.max_b = node_max_b[left];
            left++;
         end
         if (right[0]) begin
            right--;
            if (node_max_a[right] > r.max_a) r.max_a = node_max_a[right];
            if (node_max_b[right] > r.max_b) r.max_b = node_max_b[right];
         end
         left  = left >> 1;
         right = right >> 1;
      end
      return r;
   endfunction

   // values of mixed magnitude, extremes included
   function automatic logic [VAL_W-1:0] random_word();
      logic [VAL_W-1:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(63);
         3: return w >> $urandom_range(63);
         default: return w;
      endcase
   endfunction

   // one request beat; called and returning at a rising edge
   task automatic send_item(drmt_pkg::op_type op, logic [IDX_W-1:0] idx,
                            logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                            logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                            logic typed, maxima_type want);
      logic [REQ_DATA_W-1:0] beat;
      maxima_type            result;
      // fields the op does not use carry noise
      if (op == OP_WRITE) begin
         lo = $urandom;
         hi = $urandom;
      end else begin
         idx = $urandom;
         a   = random_word();
         b   = random_word();
      end
      if (!steady) begin
         while ($urandom_range(99) < 20) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      beat = '0;
      beat[REQ_IDX_LSB +: IDX_W] = idx;
      beat[REQ_A_LSB +: VAL_W]   = a;
      beat[REQ_B_LSB +: VAL_W]   = b;
      beat[REQ_LO_LSB +: IDX_W]  = lo;
      beat[REQ_HI_LSB +: IDX_W]  = hi;
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= op;
      // ready sampled mid-cycle, beat taken at the following edge
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      if (op == OP_WRITE) begin
         store_entry_pair(idx, a, b);
         writes_sent++;
      end else begin
         result = typed ? want : predict_maxima(lo, hi);
         awaited_maxima.push_back(result);
         queries_sent++;
      end
   endtask

   // random beat shaped around the entries in use
   task automatic random_item();
      int unsigned eff, span, pick, idx, lo, hi;
      eff  = (active_count > MAX_ENTRIES) ? MAX_ENTRIES : active_count;
      span = (eff < 16) ? 16 : eff;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 45) begin
         if (pick < 2) idx = 0;
         else if (pick < 5) idx = $urandom_range(MAX_ENTRIES + 1, LAST_INDEX);
         else if (pick < 15) idx = $urandom_range(1, MAX_ENTRIES);
         else idx = $urandom_range(1, span);
         send_item(OP_WRITE, idx[IDX_W-1:0], random_word(), random_word(), '0, '0,
                   1'b0, '0);
      end else begin
         if (pick < 8) begin
            lo = $urandom_range(LAST_INDEX);
            hi = $urandom_range(LAST_INDEX);
         end else if (pick < 16) begin
            lo = $urandom_range(1);
            hi = $urandom_range(eff, LAST_INDEX);
         end else begin
            lo = $urandom_range(span);
            hi = (pick < 60) ? lo + $urandom_range(40) : $urandom_range(span);
         end
         if (hi > LAST_INDEX) hi = LAST_INDEX;
         send_item(OP_QUERY, '0, '0, '0, lo[IDX_W-1:0], hi[IDX_W-1:0], 1'b0, '0);
      end
   endtask

   // stop sending, wait out every result and any trailing writes
   task automatic drain();
      req_tvalid <= 1'b0;
      while (awaited_maxima.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_entry_count(int unsigned count);
      csr_valid <= 1'b1;
      csr_wdata <= count[IDX_W-1:0];
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid    <= 1'b0;
      active_count = count;
   endtask

   // result side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 20);
      end
   end

   // scoreboard: each result beat against the oldest prediction
   always @(negedge clock) begin
      maxima_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.max_a = rsp_tdata[VAL_W-1:0];
         got.max_b = rsp_tdata[2*VAL_W-1:VAL_W];
         got.empty = rsp_tuser;
         results_seen++;
         if (got.empty) empties_seen++;
         if (awaited_maxima.size() == 0) begin
            $display("%0t: result beat with none awaited: max_a %h max_b %h empty %b",
                     $time, got.max_a, got.max_b, got.empty);
            mismatches++;
         end else begin
            want = awaited_maxima.pop_front();
            if (got.max_a !== want.max_a) begin
               $display("%0t: max_a expected %h actual %h", $time, want.max_a, got.max_a);
               mismatches++;
            end
            if (got.max_b !== want.max_b) begin
               $display("%0t: max_b expected %h actual %h", $time, want.max_b, got.max_b);
               mismatches++;
            end
            if (got.empty !== want.empty) begin
               $display("%0t: range_empty expected %b actual %b", $time, want.empty,
                        got.empty);
               mismatches++;
            end
         end
      end
   end

   // run limit, well past the slowest legal run including the clearing pass
   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: run limit reached, %0d results still awaited", $time,
               awaited_maxima.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int unsigned phase_counts [PHASES];
      for (int i = 0; i < DEPTH; i++) begin
         node_max_a[i] = '0;
         node_max_b[i] = '0;
      end
      active_count = MAX_ENTRIES;
      steady       = 1'b0;
      mismatches   = 0;
      writes_sent  = 0;
      queries_sent = 0;
      results_seen = 0;
      empties_seen = 0;
      // saturated, single entry, small, none, mid, random, full
      phase_counts = '{2047, 1, 16, 0, 600, 2 + $urandom_range(1021), MAX_ENTRIES};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (DIRECTED_PLAN[i]) begin
         send_item(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].a,
                   DIRECTED_PLAN[i].b, DIRECTED_PLAN[i].lo, DIRECTED_PLAN[i].hi,
                   DIRECTED_PLAN[i].typed,
                   '{DIRECTED_PLAN[i].want_a, DIRECTED_PLAN[i].want_b,
                     DIRECTED_PLAN[i].want_empty});
      end
      drain();

      // random phases, one entry_count setting each
      for (int p = 0; p < PHASES; p++) begin
         set_entry_count(phase_counts[p]);
         steady = (p == STEADY_PHASE);
         repeat (RANDOM_PER_PHASE) random_item();
         drain();
      end

      $display("covered %0d writes and %0d queries over %0d entry_count settings",
               writes_sent, queries_sent, PHASES);
      $display("checked %0d results, %0d empty ranges, %0d mismatches",
               results_seen, empties_seen, mismatches);
      if (mismatches == 0 && awaited_maxima.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
